[hw/rtl/poi_record_stream_parser_macros.svh]
// Assertion macros shared by the points-of-interest parser RTL.
// Each use expects signals named clock and reset in the calling module.
`ifndef POI_RECORD_STREAM_PARSER_MACROS_SVH
`define POI_RECORD_STREAM_PARSER_MACROS_SVH

// cond true at an edge implies expr true at that same edge
`define POI_ASSERT_IMPLY(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// cond true at an edge implies expr true at the following edge
`define POI_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

[hw/rtl/poi_pkg.sv]
// Package for the points-of-interest record stream parser.
// Holds parse phases, record type codes, skip counts and the result struct.
`timescale 1ns / 1ps
`default_nettype none

package poi_pkg;

   typedef enum logic [2:0] {
      PH_TYPE,
      PH_SKIP,
      PH_LENBYTE,
      PH_SIZE,
      PH_LON,
      PH_LAT,
      PH_NAME,
      PH_STOPPED
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_TRUNCATED,
      ST_UNKNOWN
   } status_type;

   // record type bytes
   localparam logic [7:0] REC_SKIP20  = 8'h01;
   localparam logic [7:0] REC_POINT   = 8'h02;
   localparam logic [7:0] REC_SKIP6   = 8'h04;
   localparam logic [7:0] REC_SKIP8A  = 8'h05;
   localparam logic [7:0] REC_SKIP8B  = 8'h15;
   localparam logic [7:0] REC_SKIP9   = 8'h06;
   localparam logic [7:0] REC_LEN07   = 8'h07;
   localparam logic [7:0] REC_LEN08   = 8'h08;
   localparam logic [7:0] REC_LEN18   = 8'h18;
   localparam logic [7:0] REC_LEN09   = 8'h09;
   localparam logic [7:0] REC_LEN19   = 8'h19;
   localparam logic [7:0] REC_LEN0A   = 8'h0a;
   localparam logic [7:0] REC_LEN1A   = 8'h1a;
   localparam logic [7:0] REC_LEN0C   = 8'h0c;

   localparam int unsigned SKIP_W = 9;

   localparam logic [SKIP_W-1:0] SKIP_CNT20   = 9'd20;
   localparam logic [SKIP_W-1:0] SKIP_CNT6    = 9'd6;
   localparam logic [SKIP_W-1:0] SKIP_CNT8    = 9'd8;
   localparam logic [SKIP_W-1:0] SKIP_CNT9    = 9'd9;
   localparam logic [SKIP_W-1:0] LEN_SKIP_BASE = 9'd6;

   // point header: type + size + two coordinate words
   localparam logic [31:0] POINT_HDR_BYTES = 32'd13;
   localparam logic [31:0] POINT_MIN_NAMED = 32'd14;

   typedef struct packed {
      logic [7:0]         name_byte;
      logic               name_valid;
      logic signed [31:0] longitude_raw;
      logic signed [31:0] latitude_raw;
      logic               last_of_record;
      status_type         status;
   } rsp_type;

endpackage

`default_nettype wire

[hw/rtl/poi_parse_core.sv]
// Record parser state machine: phase, counters, word assembly, held coordinates.
// Depends on poi_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "poi_record_stream_parser_macros.svh"

module poi_parse_core (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           advance,     // request taken this cycle
   input  wire logic [7:0]     data_byte,
   input  wire logic           end_of_file,
   output logic                emit,
   output poi_pkg::rsp_type    rsp
);

   poi_pkg::phase_type             phase_ff, phase_in, phase_step;
   logic [poi_pkg::SKIP_W-1:0]     skip_ff, skip_in, skip_dec, fixed_cnt;
   logic [31:0]                    word_ff, word_in, word_new;
   logic [1:0]                     idx_ff, idx_in;
   logic [31:0]                    name_rem_ff, name_rem_in, rem_dec;
   logic signed [31:0]             lon_ff, lon_in, lat_ff, lat_in;
   logic                           word_done, short_size, len_type, point_step;

   function automatic logic [poi_pkg::SKIP_W-1:0] fixed_skip(input logic [7:0] b);
      logic [poi_pkg::SKIP_W-1:0] n;
      begin
         unique case (b)
            poi_pkg::REC_SKIP20: n = poi_pkg::SKIP_CNT20;
            poi_pkg::REC_SKIP6:  n = poi_pkg::SKIP_CNT6;
            poi_pkg::REC_SKIP8A,
            poi_pkg::REC_SKIP8B: n = poi_pkg::SKIP_CNT8;
            poi_pkg::REC_SKIP9:  n = poi_pkg::SKIP_CNT9;
            default:             n = '0;
         endcase
         return n;
      end
   endfunction

   assign fixed_cnt = fixed_skip(data_byte);
   assign len_type  = (data_byte == poi_pkg::REC_LEN07) || (data_byte == poi_pkg::REC_LEN08) ||
                      (data_byte == poi_pkg::REC_LEN18) || (data_byte == poi_pkg::REC_LEN09) ||
                      (data_byte == poi_pkg::REC_LEN19) || (data_byte == poi_pkg::REC_LEN0A) ||
                      (data_byte == poi_pkg::REC_LEN1A) || (data_byte == poi_pkg::REC_LEN0C);

   assign skip_dec   = (skip_ff != '0) ? skip_ff - 1'b1 : skip_ff;
   assign rem_dec    = (name_rem_ff != '0) ? name_rem_ff - 32'd1 : name_rem_ff;
   assign word_new   = word_ff | (32'(data_byte) << {idx_ff, 3'b000});
   assign word_done  = (idx_ff == 2'd3);
   assign short_size = (name_rem_ff < poi_pkg::POINT_MIN_NAMED);

   // next state
   always_comb begin
      phase_step  = phase_ff;
      skip_in     = skip_ff;
      word_in     = word_ff;
      idx_in      = idx_ff;
      name_rem_in = name_rem_ff;
      lon_in      = lon_ff;
      lat_in      = lat_ff;
      unique case (phase_ff)
         poi_pkg::PH_TYPE: begin
            priority if (data_byte == poi_pkg::REC_POINT) begin
               lon_in     = '0;
               lat_in     = '0;
               word_in    = '0;
               idx_in     = '0;
               phase_step = poi_pkg::PH_SIZE;
            end else if (fixed_cnt != '0) begin
               skip_in    = fixed_cnt;
               phase_step = poi_pkg::PH_SKIP;
            end else if (len_type) begin
               phase_step = poi_pkg::PH_LENBYTE;
            end else begin
               phase_step = poi_pkg::PH_STOPPED;
            end
         end
         poi_pkg::PH_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == '0) begin
               phase_step = poi_pkg::PH_TYPE;
            end
         end
         poi_pkg::PH_LENBYTE: begin
            skip_in    = poi_pkg::LEN_SKIP_BASE + {1'b0, data_byte};
            phase_step = poi_pkg::PH_SKIP;
         end
         poi_pkg::PH_SIZE, poi_pkg::PH_LON, poi_pkg::PH_LAT: begin
            if (word_done) begin
               word_in = '0;
               idx_in  = '0;
               unique case (phase_ff)
                  poi_pkg::PH_SIZE: begin
                     name_rem_in = word_new;
                     phase_step  = poi_pkg::PH_LON;
                  end
                  poi_pkg::PH_LON: begin
                     lon_in     = word_new;
                     phase_step = poi_pkg::PH_LAT;
                  end
                  default: begin
                     lat_in = word_new;
                     if (short_size) begin
                        name_rem_in = '0;
                        phase_step  = poi_pkg::PH_TYPE;
                     end else begin
                        name_rem_in = name_rem_ff - poi_pkg::POINT_HDR_BYTES;
                        phase_step  = poi_pkg::PH_NAME;
                     end
                  end
               endcase
            end else begin
               word_in = word_new;
               idx_in  = idx_ff + 2'd1;
            end
         end
         poi_pkg::PH_NAME: begin
            name_rem_in = rem_dec;
            if (rem_dec == '0) begin
               phase_step = poi_pkg::PH_TYPE;
            end
         end
         poi_pkg::PH_STOPPED: begin
         end
         default: phase_step = poi_pkg::PH_TYPE;
      endcase

      phase_in = phase_step;
      if (end_of_file) begin
         phase_in    = poi_pkg::PH_TYPE;
         skip_in     = '0;
         word_in     = '0;
         idx_in      = '0;
         name_rem_in = '0;
      end
   end

   assign point_step = (phase_step == poi_pkg::PH_SIZE) || (phase_step == poi_pkg::PH_LON) ||
                       (phase_step == poi_pkg::PH_LAT)  || (phase_step == poi_pkg::PH_NAME);

   // result
   always_comb begin
      emit = 1'b0;
      rsp  = '0;
      unique case (phase_ff)
         poi_pkg::PH_TYPE: begin
            if (data_byte != poi_pkg::REC_POINT && fixed_cnt == '0 && !len_type) begin
               emit       = 1'b1;
               rsp.status = poi_pkg::ST_UNKNOWN;
            end
         end
         poi_pkg::PH_LAT: begin
            if (word_done && short_size) begin
               emit               = 1'b1;
               rsp.last_of_record = 1'b1;
               rsp.longitude_raw  = lon_ff;
               rsp.latitude_raw   = word_new;
            end
         end
         poi_pkg::PH_NAME: begin
            emit               = 1'b1;
            rsp.name_byte      = data_byte;
            rsp.name_valid     = 1'b1;
            rsp.longitude_raw  = lon_ff;
            rsp.latitude_raw   = lat_ff;
            rsp.last_of_record = (rem_dec == '0);
         end
         default: begin
         end
      endcase

      // file ended with a point record still open
      if (end_of_file && point_step) begin
         emit               = 1'b1;
         rsp.status         = poi_pkg::ST_TRUNCATED;
         rsp.last_of_record = 1'b1;
         rsp.longitude_raw  = lon_in;
         rsp.latitude_raw   = lat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= poi_pkg::PH_TYPE;
         skip_ff     <= '0;
         word_ff     <= '0;
         idx_ff      <= '0;
         name_rem_ff <= '0;
         lon_ff      <= '0;
         lat_ff      <= '0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         skip_ff     <= skip_in;
         word_ff     <= word_in;
         idx_ff      <= idx_in;
         name_rem_ff <= name_rem_in;
         lon_ff      <= lon_in;
         lat_ff      <= lat_in;
      end
   end

   `POI_ASSERT_IMPLY(a_unknown_clean, emit && rsp.status == poi_pkg::ST_UNKNOWN, rsp.longitude_raw == 0 && rsp.latitude_raw == 0 && !rsp.name_valid, "unknown-type result carries data")
   `POI_ASSERT_IMPLY(a_stopped_quiet, phase_ff == poi_pkg::PH_STOPPED && !end_of_file, !emit, "result while parsing is stopped")
   `POI_ASSERT_NEXT(a_eof_resets, advance && end_of_file, phase_ff == poi_pkg::PH_TYPE && idx_ff == 2'd0, "end of file did not return to type phase")

endmodule

`default_nettype wire

[hw/rtl/poi_out_skid.sv]
// Result output register with one skid entry, so one more request can be taken under a stall.
// Depends on poi_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "poi_record_stream_parser_macros.svh"

module poi_out_skid (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  poi_pkg::rsp_type       push_data,
   output logic                   push_ready,
   output logic                   out_valid,
   output poi_pkg::rsp_type       out_data,
   input  wire logic              out_ready
);

   logic             out_vld_ff, out_vld_in, skid_vld_ff, skid_vld_in;
   poi_pkg::rsp_type out_ff, out_in, skid_ff, skid_in;
   logic             out_free;

   assign push_ready = !skid_vld_ff;
   assign out_free   = !out_vld_ff || out_ready;
   assign out_valid  = out_vld_ff;
   assign out_data   = out_ff;

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_in      = out_ff;
      skid_vld_in = skid_vld_ff;
      skid_in     = skid_ff;
      if (out_free) begin
         if (skid_vld_ff) begin
            out_vld_in  = 1'b1;
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end else begin
            out_vld_in = push_valid;
            out_in     = push_data;
         end
      end else if (push_valid) begin
         skid_vld_in = 1'b1;
         skid_in     = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   `POI_ASSERT_IMPLY(a_skid_behind_out, skid_vld_ff, out_vld_ff, "skid entry held with empty output")
   `POI_ASSERT_NEXT(a_stall_to_skid, out_vld_ff && !out_ready && push_valid && !skid_vld_ff, skid_vld_ff && out_vld_ff, "stalled result lost")

endmodule

`default_nettype wire

[hw/rtl/poi_record_stream_parser.sv]
// Points-of-interest record stream parser, top level.
// Results: each result is registered in the output stage, or held in the skid entry under a stall, before rsp_*.
// Throughput: one byte per cycle while req_tready is high; the phase update and counter step are made per byte.
// Stalls: a result blocked by rsp_tready waits in a skid entry, and req_tready is low meanwhile.
// Reset: synchronous, active high; parser returns to expecting a type byte, output empties.
// Depends on poi_pkg, poi_parse_core and poi_out_skid.
`timescale 1ns / 1ps
`default_nettype none

module poi_record_stream_parser (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel: one file byte per request
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] data_byte
   input  wire logic         req_tlast,   // end_of_file
   // result channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [71:0]       rsp_tdata,   // [7:0] name_byte, [39:8] longitude_raw,
                                          // [71:40] latitude_raw
   output logic              rsp_tlast,   // last_of_record
   output logic [2:0]        rsp_tuser    // [0] name_valid, [2:1] status
);

   logic             req_take;
   logic             emit;
   poi_pkg::rsp_type core_rsp, out_rsp;

   // a request is taken whenever the skid entry is free
   assign req_take = req_tvalid && req_tready;

   poi_parse_core u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (req_take),
      .data_byte   (req_tdata),
      .end_of_file (req_tlast),
      .emit        (emit),
      .rsp         (core_rsp)
   );

   poi_out_skid u_out (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_take && emit),
      .push_data  (core_rsp),
      .push_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_data   (out_rsp),
      .out_ready  (rsp_tready)
   );

   assign rsp_tdata = {out_rsp.latitude_raw, out_rsp.longitude_raw, out_rsp.name_byte};
   assign rsp_tlast = out_rsp.last_of_record;
   assign rsp_tuser = {out_rsp.status, out_rsp.name_valid};

endmodule

`default_nettype wire
